FILE: src/epoch_to_utc_calendar_core_defines.svh
`ifndef EPOCH_TO_UTC_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_TO_UTC_CALENDAR_CORE_DEFINES_SVH

// implication check, sampled on the rising clock edge, off during reset
`define ECAL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never be seen outside reset
`define ECAL_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: src/ecal_pkg.sv
package ecal_pkg;

   localparam int EpochW  = 32;
   localparam int YearW   = 12;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int HourW   = 5;
   localparam int MinuteW = 6;
   localparam int SecondW = 6;

   localparam int DaysW = 16;
   localparam int SodW  = 17;
   localparam int DoeW  = 18;
   localparam int YoeW  = 9;
   localparam int DoyW  = 9;
   localparam int MpW   = 4;

   // input register, six work stages, result register
   localparam int PipeDepth = 8;

   // t / 86400 = (t >> 7) / 675
   localparam int DayShift = 35;
   localparam logic [25:0] DayRecip = 26'(((64'd1 << DayShift) + 64'd674) / 64'd675);
   localparam logic [9:0]  DayOdd   = 10'd675;

   localparam logic [19:0] CivilShift = 20'd719468;
   localparam logic [19:0] EraBase5   = 20'd730485;
   localparam logic [19:0] EraBase4   = 20'd584388;

   // doe / 1460 = (doe >> 2) / 365
   localparam int QuadShift = 25;
   localparam logic [16:0] QuadRecip = 17'(((64'd1 << QuadShift) + 64'd364) / 64'd365);

   localparam logic [DoeW-1:0] Cent1 = 18'd36524;
   localparam logic [DoeW-1:0] Cent2 = 18'd73048;
   localparam logic [DoeW-1:0] Cent3 = 18'd109572;
   localparam logic [DoeW-1:0] Cent4 = 18'd146096;

   localparam int YearShift = 27;
   localparam logic [18:0] YearRecip = 19'(((64'd1 << YearShift) + 64'd364) / 64'd365);
   localparam logic [8:0]  YearDays  = 9'd365;

   localparam int MonthShift = 19;
   localparam logic [11:0] MonthRecip = 12'(((64'd1 << MonthShift) + 64'd152) / 64'd153);

   // sod / 3600 = (sod >> 4) / 225
   localparam int HourShift = 21;
   localparam logic [13:0] HourRecip = 14'(((64'd1 << HourShift) + 64'd224) / 64'd225);
   localparam logic [11:0] HourSecs  = 12'd3600;

   // remh / 60 = (remh >> 2) / 15
   localparam int MinuteShift = 14;
   localparam logic [10:0] MinuteRecip = 11'(((64'd1 << MinuteShift) + 64'd14) / 64'd15);
   localparam logic [5:0]  MinuteSecs  = 6'd60;

   localparam logic [YearW-1:0] EraYear4 = 12'd1600;
   localparam logic [YearW-1:0] EraYear5 = 12'd2000;

   typedef struct packed {
      logic [YearW-1:0]  year;
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
   } date_type;

   typedef struct packed {
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } clock_type;

   // first day of each March-based month within the year
   function automatic logic [DoyW-1:0] month_offset(input logic [MpW-1:0] mp);
      logic [DoyW-1:0] off;
      case (mp)
         4'd0:  off = 9'd0;
         4'd1:  off = 9'd31;
         4'd2:  off = 9'd61;
         4'd3:  off = 9'd92;
         4'd4:  off = 9'd122;
         4'd5:  off = 9'd153;
         4'd6:  off = 9'd184;
         4'd7:  off = 9'd214;
         4'd8:  off = 9'd245;
         4'd9:  off = 9'd275;
         4'd10: off = 9'd306;
         4'd11: off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

FILE: src/ecal_date_path.sv
module ecal_date_path
   import ecal_pkg::*;
(
   input  logic            clock,
   input  logic [DoeW-1:0] doe,
   input  logic            era5,
   output date_type        date_out
);

   // stage 3: century-corrected day count
   logic [15:0]     quad;
   logic [32:0]     quad_prod;
   logic [7:0]      quads;
   logic [2:0]      cents;
   logic            last_day;
   logic [DoeW-1:0] num_in;
   logic [DoeW-1:0] num_ff;
   logic [DoeW-1:0] doe3_ff;
   logic            era3_ff;

   assign quad      = doe[DoeW-1:2];
   assign quad_prod = quad * QuadRecip;
   assign quads     = quad_prod[32:QuadShift];
   assign cents     = 3'(doe >= Cent1) + 3'(doe >= Cent2) + 3'(doe >= Cent3)
                    + 3'(doe >= Cent4);
   assign last_day  = (doe >= Cent4);
   assign num_in    = doe - DoeW'(quads) + DoeW'(cents) - DoeW'(last_day);

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      doe3_ff <= doe;
      era3_ff <= era5;
   end

   // stage 4: year of era
   logic [36:0]     yoe_prod;
   logic [YoeW-1:0] yoe_in;
   logic [YoeW-1:0] yoe4_ff;
   logic [DoeW-1:0] doe4_ff;
   logic            era4_ff;

   assign yoe_prod = num_ff * YearRecip;
   assign yoe_in   = yoe_prod[YearShift+YoeW-1:YearShift];

   always_ff @(posedge clock) begin
      yoe4_ff <= yoe_in;
      doe4_ff <= doe3_ff;
      era4_ff <= era3_ff;
   end

   // stage 5: day of March-based year
   logic [1:0]      yoe_cents;
   logic [DoeW-1:0] year_start;
   logic [DoyW-1:0] doy_in;
   logic [DoyW-1:0] doy5_ff;
   logic [YoeW-1:0] yoe5_ff;
   logic            era5_ff;

   assign yoe_cents  = 2'(yoe4_ff >= 9'd100) + 2'(yoe4_ff >= 9'd200)
                     + 2'(yoe4_ff >= 9'd300);
   assign year_start = DoeW'(yoe4_ff * YearDays) + DoeW'(yoe4_ff[YoeW-1:2])
                     - DoeW'(yoe_cents);
   assign doy_in     = DoyW'(doe4_ff - year_start);

   always_ff @(posedge clock) begin
      doy5_ff <= doy_in;
      yoe5_ff <= yoe4_ff;
      era5_ff <= era4_ff;
   end

   // stage 6: March-based month
   logic [10:0]    mnum;
   logic [22:0]    mp_prod;
   logic [MpW-1:0] mp_in;
   logic [MpW-1:0] mp6_ff;
   logic [DoyW-1:0] doy6_ff;
   logic [YoeW-1:0] yoe6_ff;
   logic            era6_ff;

   assign mnum    = 11'(doy5_ff * 3'd5) + 11'd2;
   assign mp_prod = mnum * MonthRecip;
   assign mp_in   = mp_prod[MonthShift+MpW-1:MonthShift];

   always_ff @(posedge clock) begin
      mp6_ff  <= mp_in;
      doy6_ff <= doy5_ff;
      yoe6_ff <= yoe5_ff;
      era6_ff <= era5_ff;
   end

   // result register
   logic            jan_feb;
   date_type        date_in;
   date_type        date_ff;

   assign jan_feb       = (mp6_ff >= 4'd10);
   assign date_in.day   = DayW'(doy6_ff - month_offset(mp6_ff) + 9'd1);
   assign date_in.month = jan_feb ? (mp6_ff - 4'd9) : (mp6_ff + 4'd3);
   assign date_in.year  = YearW'(yoe6_ff) + (era6_ff ? EraYear5 : EraYear4)
                        + YearW'(jan_feb);

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   assign date_out = date_ff;

endmodule

FILE: src/ecal_time_path.sv
module ecal_time_path
   import ecal_pkg::*;
(
   input  logic            clock,
   input  logic [SodW-1:0] sod,
   output clock_type       time_out
);

   // stage 3: hour
   logic [26:0]        hour_prod;
   logic [HourW-1:0]   hour_in;
   logic [HourW-1:0]   hour3_ff;
   logic [SodW-1:0]    sod3_ff;

   assign hour_prod = sod[SodW-1:4] * HourRecip;
   assign hour_in   = hour_prod[HourShift+HourW-1:HourShift];

   always_ff @(posedge clock) begin
      hour3_ff <= hour_in;
      sod3_ff  <= sod;
   end

   // stage 4: seconds within the hour
   logic [11:0]        remh_in;
   logic [11:0]        remh4_ff;
   logic [HourW-1:0]   hour4_ff;

   assign remh_in = 12'(sod3_ff - SodW'(hour3_ff * HourSecs));

   always_ff @(posedge clock) begin
      remh4_ff <= remh_in;
      hour4_ff <= hour3_ff;
   end

   // stage 5: minute
   logic [20:0]        min_prod;
   logic [MinuteW-1:0] minute_in;
   logic [MinuteW-1:0] minute5_ff;
   logic [11:0]        remh5_ff;
   logic [HourW-1:0]   hour5_ff;

   assign min_prod  = remh4_ff[11:2] * MinuteRecip;
   assign minute_in = min_prod[MinuteShift+MinuteW-1:MinuteShift];

   always_ff @(posedge clock) begin
      minute5_ff <= minute_in;
      remh5_ff   <= remh4_ff;
      hour5_ff   <= hour4_ff;
   end

   // stage 6: second
   logic [SecondW-1:0] second_in;
   clock_type          time6_ff;
   clock_type          time_ff;

   assign second_in = SecondW'(remh5_ff - 12'(minute5_ff * MinuteSecs));

   always_ff @(posedge clock) begin
      time6_ff.hour   <= hour5_ff;
      time6_ff.minute <= minute5_ff;
      time6_ff.second <= second_in;
   end

   // result register
   always_ff @(posedge clock) begin
      time_ff <= time6_ff;
   end

   assign time_out = time_ff;

endmodule

FILE: src/epoch_to_utc_calendar_core.sv
// channel   direction  handshake              item
// request   in         start (busy always 0)  req_epoch_seconds
// response  out        rsp_strobe, 1 cycle    rsp_year_out .. rsp_second_out
//
// Fully pipelined: one item per cycle, every cycle.
// Eight registers deep: input register, six stages and the result register;
// the strobe is aligned with the output of the result register.
// Synchronous reset clears the valid pipeline only; items in flight are dropped.
// The receiver cannot stall; busy stays low.

`include "epoch_to_utc_calendar_core_defines.svh"

module epoch_to_utc_calendar_core
   import ecal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [EpochW-1:0]  req_epoch_seconds,
   output logic               rsp_strobe,
   output logic [YearW-1:0]   rsp_year_out,
   output logic [MonthW-1:0]  rsp_month_out,
   output logic [DayW-1:0]    rsp_day_out,
   output logic [HourW-1:0]   rsp_hour_out,
   output logic [MinuteW-1:0] rsp_minute_out,
   output logic [SecondW-1:0] rsp_second_out
);

   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[PipeDepth-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // input register
   logic [EpochW-1:0] t0_ff;

   always_ff @(posedge clock) begin
      t0_ff <= req_epoch_seconds;
   end

   // stage 1: day count
   logic [24:0]       t0_hi;
   logic [50:0]       day_prod;
   logic [DaysW-1:0]  days_in;
   logic [DaysW-1:0]  days_ff;
   logic [EpochW-1:0] t1_ff;

   assign t0_hi    = t0_ff[EpochW-1:7];
   assign day_prod = t0_hi * DayRecip;
   assign days_in  = day_prod[DayShift+DaysW-1:DayShift];

   always_ff @(posedge clock) begin
      days_ff <= days_in;
      t1_ff   <= t0_ff;
   end

   // stage 2: second of day, era and day of era
   logic [9:0]       day_rem;
   logic [SodW-1:0]  sod_in;
   logic [19:0]      z;
   logic             era5_in;
   logic [DoeW-1:0]  doe_in;
   logic [SodW-1:0]  sod_ff;
   logic [DoeW-1:0]  doe_ff;
   logic             era5_ff;

   assign day_rem = 10'(t1_ff[EpochW-1:7] - 25'(days_ff * DayOdd));
   assign sod_in  = {day_rem, t1_ff[6:0]};
   assign z       = 20'(days_ff) + CivilShift;
   assign era5_in = (z >= EraBase5);
   assign doe_in  = DoeW'(z - (era5_in ? EraBase5 : EraBase4));

   always_ff @(posedge clock) begin
      sod_ff  <= sod_in;
      doe_ff  <= doe_in;
      era5_ff <= era5_in;
   end

   date_type  date_res;
   clock_type time_res;

   ecal_date_path u_date (
      .clock    (clock),
      .doe      (doe_ff),
      .era5     (era5_ff),
      .date_out (date_res)
   );

   ecal_time_path u_time (
      .clock    (clock),
      .sod      (sod_ff),
      .time_out (time_res)
   );

   assign rsp_strobe     = valid_ff[PipeDepth-1];
   assign rsp_year_out   = date_res.year;
   assign rsp_month_out  = date_res.month;
   assign rsp_day_out    = date_res.day;
   assign rsp_hour_out   = time_res.hour;
   assign rsp_minute_out = time_res.minute;
   assign rsp_second_out = time_res.second;

   logic year_ok;
   logic fields_ok;
   logic short_month;
   logic feb_late;

   assign year_ok     = (rsp_year_out >= 12'd1970) && (rsp_year_out <= 12'd2106);
   assign fields_ok   = (rsp_month_out >= 4'd1) && (rsp_month_out <= 4'd12)
                      && (rsp_day_out >= 5'd1) && (rsp_hour_out <= 5'd23)
                      && (rsp_minute_out <= 6'd59) && (rsp_second_out <= 6'd59);
   assign short_month = (rsp_day_out == 5'd31)
                      && ((rsp_month_out == 4'd4) || (rsp_month_out == 4'd6)
                      || (rsp_month_out == 4'd9) || (rsp_month_out == 4'd11));
   assign feb_late    = (rsp_month_out == 4'd2) && (rsp_day_out > 5'd29);

   `ECAL_ASSERT_IMP(a_strobe_start, rsp_strobe, $past(start, PipeDepth), "strobe without start")
   `ECAL_ASSERT_IMP(a_year_range, rsp_strobe, year_ok, "year out of range")
   `ECAL_ASSERT_IMP(a_fields_range, rsp_strobe, fields_ok, "field out of range")
   `ECAL_ASSERT_NEVER(a_short_month, rsp_strobe && short_month, "day 31 in a 30-day month")
   `ECAL_ASSERT_NEVER(a_february, rsp_strobe && feb_late, "February past day 29")

endmodule
